// ----- rtl/core/pvp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvp_pkg
// shared widths, register map and control bundle of the vertex projection
// ----------------------------------------------------------------------------
package pvp_pkg;

    localparam int CAM_W   = 55;   // camera coordinate, Q.30 signed
    localparam int MAG_W   = 54;   // camera magnitude
    localparam int NEAR_W  = 31;
    localparam int SN_W    = 85;   // screen numerator |cam| * near
    localparam int SQ_W    = 41;   // screen quotient bits
    localparam int RS_W    = 42;   // screen value, Q.24 signed
    localparam int RA_W    = 55;   // raster numerator before scaling
    localparam int RM_W    = 54;
    localparam int RN_W    = 70;   // raster numerator times 65536
    localparam int RQ_W    = 32;
    localparam int RD_W    = 33;   // |2 * edge|

    localparam logic [SQ_W-1:0] SCR_LIM = 41'h100_0000_0000;
    localparam logic [RD_W-1:0] RAS_LIM = 33'h0_8000_0000;

    typedef enum logic [2:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_TRANS   = 3'd3,
        REG_NEAR    = 3'd4,
        REG_WIN_H   = 3'd5,
        REG_WIN_V   = 3'd6,
        REG_IMG     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic zero_depth;
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
        logic visible;
    } sb_t;

    function automatic logic signed [20:0] entry21(input logic [62:0] r, input int k);
        return $signed(r[21*k +: 21]);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pvp_delay.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvp_delay
// enabled shift line that carries control bits beside the dividers
// ----------------------------------------------------------------------------
module pvp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic [W-1:0] d_in,
    output logic      [W-1:0] d_out
);

    logic [W-1:0] stage_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) stage_reg[i] <= '0;
        end else if (en) begin
            stage_reg[0] <= d_in;
            for (int i = 1; i < DEPTH; i++) stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign d_out = stage_reg[DEPTH-1];

endmodule
`default_nettype wire

// ----- rtl/core/pvp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvp_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
module pvp_div #(
    parameter int NW = 85,
    parameter int DW = 54,
    parameter int QW = 41
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] n_in,
    input  wire logic [DW-1:0] d_in,
    output logic      [QW-1:0] q_out,
    output logic               ovf_out
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] d_ext;

    logic [DW-1:0] r_reg   [0:QW-1];
    logic [QW-1:0] n_reg   [0:QW];
    logic [DW-1:0] d_reg   [0:QW-1];
    logic          ovf_reg [0:QW];

    assign hi_ext = CW'(n_in[NW-1:QW]);
    assign d_ext  = CW'(d_in);

    // quotient would not fit in QW bits
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= hi_ext[DW-1:0];
            n_reg[0]   <= n_in[QW-1:0];
            d_reg[0]   <= d_in;
            ovf_reg[0] <= (hi_ext >= d_ext);
        end
    end

    // numerator bits shift out on top, quotient bits shift in below
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   rs;
        logic          ge;
        logic [DW-1:0] r_next;

        assign rs     = {r_reg[k], n_reg[k][QW-1]};
        assign ge     = (rs >= {1'b0, d_reg[k]});
        assign r_next = ge ? DW'(rs - {1'b0, d_reg[k]}) : rs[DW-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k+1]   <= {n_reg[k][QW-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k+1] <= r_next;
                    d_reg[k+1] <= d_reg[k];
                end
            end
        end
    end

    assign q_out   = n_reg[QW];
    assign ovf_out = ovf_reg[QW];

endmodule
`default_nettype wire

// ----- rtl/core/pvp_camera.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvp_camera
// world to camera transform: product stage then sum stage
// ----------------------------------------------------------------------------
module pvp_camera (
    input  wire logic                             aclk,
    input  wire logic                             en,
    input  wire logic signed [31:0]               world_x,
    input  wire logic signed [31:0]               world_y,
    input  wire logic signed [31:0]               world_z,
    input  wire logic [62:0]                      row_x,
    input  wire logic [62:0]                      row_y,
    input  wire logic [62:0]                      row_z,
    input  wire logic [62:0]                      trans,
    output logic signed [pvp_pkg::CAM_W-1:0]      cam_x,
    output logic signed [pvp_pkg::CAM_W-1:0]      cam_y,
    output logic signed [pvp_pkg::CAM_W-1:0]      cam_z
);
    import pvp_pkg::*;

    logic signed [52:0]      px_reg [0:2];
    logic signed [52:0]      py_reg [0:2];
    logic signed [52:0]      pz_reg [0:2];
    logic signed [36:0]      pt_reg [0:2];
    logic signed [CAM_W-1:0] cam_reg [0:2];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [CAM_W-1:0] cam_next;

        assign cam_next = CAM_W'(px_reg[k]) + CAM_W'(py_reg[k])
                        + CAM_W'(pz_reg[k]) + CAM_W'(pt_reg[k]);

        always_ff @(posedge aclk) begin
            if (en) begin
                px_reg[k]  <= 53'(world_x) * 53'(entry21(row_x, k));
                py_reg[k]  <= 53'(world_y) * 53'(entry21(row_y, k));
                pz_reg[k]  <= 53'(world_z) * 53'(entry21(row_z, k));
                pt_reg[k]  <= {entry21(trans, k), 16'b0};
                cam_reg[k] <= cam_next;
            end
        end
    end

    assign cam_x = cam_reg[0];
    assign cam_y = cam_reg[1];
    assign cam_z = cam_reg[2];

endmodule
`default_nettype wire

// ----- rtl/core/pinhole_vertex_projection_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_vertex_projection_top
// world vertex to raster position with window visibility flag
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  s_*      in         tdata: world_x, world_y, world_z (Q16.16)
//  m_*      out        tdata: raster_x, raster_y (Q16.16); tuser: visible
//  apb      in/out     eight 64-bit registers at byte address 8*i
//
//  one vertex per cycle enters unless a stall holds it; the stages run camera
//  transform, screen setup, screen divider, raster setup, raster divider and
//  output. the two long restoring dividers make up most of the pipeline.
//  synchronous active-low reset clears valid bits and loads configuration defaults.
//  a stall at m_tready freezes the whole pipeline with one enable; s_tready
//  follows that enable, so a waiting result holds the input back.
// ----------------------------------------------------------------------------
module pinhole_vertex_projection_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // world_x [31:0], world_y [63:32], world_z [95:64]
    input  wire logic [95:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // raster_x [31:0], raster_y [63:32]
    output logic [63:0]      m_tdata,
    // visible [0]
    output logic             m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import pvp_pkg::*;

    localparam int SB_W = $bits(sb_t);

    // configuration registers
    logic [62:0] row_x_reg, row_y_reg, row_z_reg, trans_reg;
    logic [30:0] near_reg;
    logic [63:0] win_h_reg, win_v_reg;
    logic [23:0] img_reg;
    logic        wr_en;
    cfg_idx_t    wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = cfg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
            trans_reg <= '0;
            near_reg  <= 31'd1677722;
            win_h_reg <= '0;
            win_v_reg <= '0;
            img_reg   <= 24'd7864960;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_ROW_X: row_x_reg <= pwdata[62:0];
                REG_ROW_Y: row_y_reg <= pwdata[62:0];
                REG_ROW_Z: row_z_reg <= pwdata[62:0];
                REG_TRANS: trans_reg <= pwdata[62:0];
                REG_NEAR:  near_reg  <= pwdata[30:0];
                REG_WIN_H: win_h_reg <= pwdata;
                REG_WIN_V: win_v_reg <= pwdata;
                REG_IMG:   img_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx_t'(paddr[5:3]))
            REG_ROW_X: prdata = {1'b0, row_x_reg};
            REG_ROW_Y: prdata = {1'b0, row_y_reg};
            REG_ROW_Z: prdata = {1'b0, row_z_reg};
            REG_TRANS: prdata = {1'b0, trans_reg};
            REG_NEAR:  prdata = {33'b0, near_reg};
            REG_WIN_H: prdata = win_h_reg;
            REG_WIN_V: prdata = win_v_reg;
            REG_IMG:   prdata = {40'b0, img_reg};
            default:   prdata = '0;
        endcase
    end

    // window edges and image size
    logic signed [RS_W-1:0] left_e, right_e, bottom_e, top_e;
    logic signed [31:0]     right_w, top_w;
    logic        [11:0]     width_w, height_w;

    assign right_w  = $signed(win_h_reg[63:32]);
    assign top_w    = $signed(win_v_reg[63:32]);
    assign left_e   = RS_W'($signed(win_h_reg[31:0]));
    assign right_e  = RS_W'(right_w);
    assign bottom_e = RS_W'($signed(win_v_reg[31:0]));
    assign top_e    = RS_W'(top_w);
    assign width_w  = img_reg[11:0];
    assign height_w = img_reg[23:12];

    // single pipeline enable, a waiting result freezes every stage
    logic m_valid_reg;
    logic en;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // camera transform, two stages
    logic signed [CAM_W-1:0] cam_x, cam_y, cam_z;
    logic                    v1_reg, v2_reg;

    pvp_camera u_camera (
        .aclk    (aclk),
        .en      (en),
        .world_x ($signed(s_tdata[31:0])),
        .world_y ($signed(s_tdata[63:32])),
        .world_z ($signed(s_tdata[95:64])),
        .row_x   (row_x_reg),
        .row_y   (row_y_reg),
        .row_z   (row_z_reg),
        .trans   (trans_reg),
        .cam_x   (cam_x),
        .cam_y   (cam_y),
        .cam_z   (cam_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // screen setup: magnitudes, partial products, numerator
    logic [MAG_W-1:0]  mag_x_reg, mag_y_reg, mag_z_reg;
    logic [62:0]       ppx_lo_reg, ppy_lo_reg;
    logic [52:0]       ppx_hi_reg, ppy_hi_reg;
    logic [MAG_W-1:0]  d4_reg, d5_reg;
    logic [SN_W-1:0]   nx_reg, ny_reg;
    sb_t               sb3_reg, sb4_reg, sb5_reg;
    sb_t               sb3_next;
    logic              cz_pos;

    assign cz_pos = !cam_z[CAM_W-1] && (cam_z != '0);

    always_comb begin
        sb3_next            = '0;
        sb3_next.valid      = v2_reg;
        sb3_next.zero_depth = (cam_z == '0);
        sb3_next.neg_x      = cam_x[CAM_W-1] != cz_pos;
        sb3_next.neg_y      = cam_y[CAM_W-1] != cz_pos;
        sb3_next.zero_x     = (cam_x == '0);
        sb3_next.zero_y     = (cam_y == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb3_reg <= '0;
            sb4_reg <= '0;
            sb5_reg <= '0;
        end else if (en) begin
            sb3_reg <= sb3_next;
            sb4_reg <= sb3_reg;
            sb5_reg <= sb4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_x_reg  <= cam_x[CAM_W-1] ? MAG_W'(-cam_x) : MAG_W'(cam_x);
            mag_y_reg  <= cam_y[CAM_W-1] ? MAG_W'(-cam_y) : MAG_W'(cam_y);
            mag_z_reg  <= cam_z[CAM_W-1] ? MAG_W'(-cam_z) : MAG_W'(cam_z);
            ppx_lo_reg <= 63'(mag_x_reg[31:0]) * 63'(near_reg);
            ppx_hi_reg <= 53'(mag_x_reg[MAG_W-1:32]) * 53'(near_reg);
            ppy_lo_reg <= 63'(mag_y_reg[31:0]) * 63'(near_reg);
            ppy_hi_reg <= 53'(mag_y_reg[MAG_W-1:32]) * 53'(near_reg);
            d4_reg     <= mag_z_reg;
            nx_reg     <= SN_W'(ppx_lo_reg) + (SN_W'(ppx_hi_reg) << 32);
            ny_reg     <= SN_W'(ppy_lo_reg) + (SN_W'(ppy_hi_reg) << 32);
            d5_reg     <= d4_reg;
        end
    end

    // screen dividers
    logic [SQ_W-1:0] qsx, qsy;
    logic            osx, osy;
    logic [SB_W-1:0] sb_sd;
    sb_t             sb_s;

    pvp_div #(.NW(SN_W), .DW(MAG_W), .QW(SQ_W)) u_sdiv_x (
        .aclk (aclk), .en (en), .n_in (nx_reg), .d_in (d5_reg),
        .q_out (qsx), .ovf_out (osx)
    );

    pvp_div #(.NW(SN_W), .DW(MAG_W), .QW(SQ_W)) u_sdiv_y (
        .aclk (aclk), .en (en), .n_in (ny_reg), .d_in (d5_reg),
        .q_out (qsy), .ovf_out (osy)
    );

    pvp_delay #(.W(SB_W), .DEPTH(SQ_W + 1)) u_sdly (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .d_in (SB_W'(sb5_reg)), .d_out (sb_sd)
    );

    assign sb_s = sb_t'(sb_sd);

    // screen result, saturated at 2^40 in magnitude
    logic [SQ_W-1:0]        qsx_c, qsy_c;
    logic signed [RS_W-1:0] sx_reg, sy_reg;
    sb_t                    sb6_reg;

    assign qsx_c = sb_s.zero_x ? '0 : ((osx || qsx > SCR_LIM) ? SCR_LIM : qsx);
    assign qsy_c = sb_s.zero_y ? '0 : ((osy || qsy > SCR_LIM) ? SCR_LIM : qsy);

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= sb_s.neg_x ? -$signed({1'b0, qsx_c}) : $signed({1'b0, qsx_c});
            sy_reg <= sb_s.neg_y ? -$signed({1'b0, qsy_c}) : $signed({1'b0, qsy_c});
        end
    end

    // raster setup: offset and visibility, scale, magnitudes
    logic signed [RS_W-1:0] sumx_reg, sumy_reg;
    logic signed [RA_W-1:0] ax_reg, ay_reg;
    logic [RN_W-1:0]        rnx_reg, rny_reg;
    logic [RD_W-1:0]        rdx_reg, rdy_reg;
    logic signed [RD_W-1:0] two_r, two_t;
    sb_t                    sb7_reg, sb8_reg, sb9_reg;
    sb_t                    sb7_next, sb9_next;

    assign two_r = {right_w, 1'b0};
    assign two_t = {top_w, 1'b0};

    always_comb begin
        sb7_next         = sb6_reg;
        sb7_next.visible = !(sx_reg < left_e || sx_reg > right_e
                             || sy_reg < bottom_e || sy_reg > top_e);
        sb9_next         = sb8_reg;
        sb9_next.neg_x   = ax_reg[RA_W-1] != right_w[31];
        sb9_next.neg_y   = ay_reg[RA_W-1] != top_w[31];
        sb9_next.zero_x  = (ax_reg == '0);
        sb9_next.zero_y  = (ay_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb6_reg <= '0;
            sb7_reg <= '0;
            sb8_reg <= '0;
            sb9_reg <= '0;
        end else if (en) begin
            sb6_reg <= sb_s;
            sb7_reg <= sb7_next;
            sb8_reg <= sb7_reg;
            sb9_reg <= sb9_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sumx_reg <= sx_reg + right_e;
            sumy_reg <= top_e - sy_reg;
            ax_reg   <= RA_W'(sumx_reg) * RA_W'($signed({1'b0, width_w}));
            ay_reg   <= RA_W'(sumy_reg) * RA_W'($signed({1'b0, height_w}));
            rnx_reg  <= {(ax_reg[RA_W-1] ? RM_W'(-ax_reg) : RM_W'(ax_reg)), 16'b0};
            rny_reg  <= {(ay_reg[RA_W-1] ? RM_W'(-ay_reg) : RM_W'(ay_reg)), 16'b0};
            rdx_reg  <= right_w[31] ? RD_W'(-two_r) : RD_W'(two_r);
            rdy_reg  <= top_w[31] ? RD_W'(-two_t) : RD_W'(two_t);
        end
    end

    // raster dividers
    logic [RQ_W-1:0] qrx, qry;
    logic            orx, ory;
    logic [SB_W-1:0] sb_rd;
    sb_t             sb_r;

    pvp_div #(.NW(RN_W), .DW(RD_W), .QW(RQ_W)) u_rdiv_x (
        .aclk (aclk), .en (en), .n_in (rnx_reg), .d_in (rdx_reg),
        .q_out (qrx), .ovf_out (orx)
    );

    pvp_div #(.NW(RN_W), .DW(RD_W), .QW(RQ_W)) u_rdiv_y (
        .aclk (aclk), .en (en), .n_in (rny_reg), .d_in (rdy_reg),
        .q_out (qry), .ovf_out (ory)
    );

    pvp_delay #(.W(SB_W), .DEPTH(RQ_W + 1)) u_rdly (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .d_in (SB_W'(sb9_reg)), .d_out (sb_rd)
    );

    assign sb_r = sb_t'(sb_rd);

    // raster result: saturate at 2^31, clamp into signed 32 bits
    logic [RD_W-1:0]        qrx_c, qry_c;
    logic signed [RD_W:0]   rx_s, ry_s;
    logic [31:0]            rx_o, ry_o;
    logic [31:0]            rx_reg, ry_reg;
    logic                   vis_reg;

    assign qrx_c = sb_r.zero_x ? '0
                 : ((orx || {1'b0, qrx} > RAS_LIM) ? RAS_LIM : {1'b0, qrx});
    assign qry_c = sb_r.zero_y ? '0
                 : ((ory || {1'b0, qry} > RAS_LIM) ? RAS_LIM : {1'b0, qry});
    assign rx_s  = sb_r.neg_x ? -$signed({1'b0, qrx_c}) : $signed({1'b0, qrx_c});
    assign ry_s  = sb_r.neg_y ? -$signed({1'b0, qry_c}) : $signed({1'b0, qry_c});
    assign rx_o  = (rx_s > $signed(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : rx_s[31:0];
    assign ry_o  = (ry_s > $signed(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : ry_s[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sb_r.valid;
        end
    end

    // zero depth forces both raster values high and hides the point
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg  <= sb_r.zero_depth ? 32'h7FFF_FFFF : rx_o;
            ry_reg  <= sb_r.zero_depth ? 32'h7FFF_FFFF : ry_o;
            vis_reg <= sb_r.visible && !sb_r.zero_depth;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ry_reg, rx_reg};
    assign m_tuser  = vis_reg;

endmodule
`default_nettype wire
